### sv/rcd_pkg.sv
package rcd_pkg;

    localparam int DEPTH  = 1024;
    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int MODE_W = 3;
    localparam int VAL_W  = 8;
    localparam int IDX_W  = 10;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 11;
    localparam int CMP_W  = (CW > IDX_W) ? CW : IDX_W;

    typedef enum logic [MODE_W-1:0]
    {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_REVERSE    = 3'd4,
        MODE_READ       = 3'd5
    } mode_t;

    typedef enum logic [STAT_W-1:0]
    {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef struct packed
    {
        logic             wr_en;
        logic             rd_en;
        logic [AW-1:0]    addr;
        logic [VAL_W-1:0] wdata;
    } mem_req_t;

    typedef struct packed
    {
        logic          rd_ok;
        status_t       status;
        logic [CW-1:0] count;
    } op_result_t;

    // Sum of two positions below DEPTH folded back into the store
    function automatic logic [AW-1:0] wrap_pos(input logic [AW:0] p);
        logic [AW:0] q;
        q = p - (AW+1)'(DEPTH);
        return (p >= (AW+1)'(DEPTH)) ? q[AW-1:0] : p[AW-1:0];
    endfunction

endpackage

### sv/rcd_mem.sv
module rcd_mem
    import rcd_pkg::*;
(
    input  logic             clk,
    input  mem_req_t         req,
    output logic [VAL_W-1:0] rdata
);

    logic [VAL_W-1:0] store_mem [DEPTH];
    logic [VAL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            store_mem[req.addr] <= req.wdata;
        end
        if (req.rd_en)
        begin
            rdata_reg <= store_mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/rcd_ctrl.sv
module rcd_ctrl
    import rcd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [MODE_W-1:0] mode,
    input  logic [VAL_W-1:0]  value,
    input  logic [IDX_W-1:0]  index,
    output mem_req_t          req,
    output op_result_t        res_next
);

    logic [AW-1:0] head_reg;
    logic [AW-1:0] head_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          rev_reg;
    logic          rev_next;
    logic [AW-1:0] off;
    logic          phys_front;

    always_comb
    begin
        head_next        = head_reg;
        count_next       = count_reg;
        rev_next         = rev_reg;
        req              = '0;
        req.wdata        = value;
        res_next.rd_ok   = 1'b0;
        res_next.status  = STATUS_OK;
        off              = '0;
        phys_front       = 1'b0;

        if (accept)
        begin
            case (mode)
                MODE_PUSH_FRONT, MODE_PUSH_BACK:
                begin
                    phys_front = (mode == MODE_PUSH_FRONT) != rev_reg;
                    if (count_reg >= CW'(DEPTH))
                    begin
                        res_next.status = STATUS_FULL;
                    end
                    else
                    begin
                        req.wr_en  = 1'b1;
                        count_next = count_reg + CW'(1);
                        if (phys_front)
                        begin
                            head_next = (head_reg == '0) ? AW'(DEPTH - 1)
                                                         : head_reg - AW'(1);
                            req.addr  = head_next;
                        end
                        else
                        begin
                            off      = AW'(count_reg);
                            req.addr = wrap_pos((AW+1)'(head_reg) + (AW+1)'(off));
                        end
                    end
                end
                MODE_POP_FRONT, MODE_POP_BACK:
                begin
                    phys_front = (mode == MODE_POP_FRONT) != rev_reg;
                    if (count_reg == '0)
                    begin
                        res_next.status = STATUS_EMPTY;
                    end
                    else
                    begin
                        req.rd_en      = 1'b1;
                        res_next.rd_ok = 1'b1;
                        count_next     = count_reg - CW'(1);
                        if (phys_front)
                        begin
                            req.addr  = head_reg;
                            head_next = wrap_pos((AW+1)'(head_reg) + (AW+1)'(1));
                        end
                        else
                        begin
                            off      = AW'(count_reg - CW'(1));
                            req.addr = wrap_pos((AW+1)'(head_reg) + (AW+1)'(off));
                        end
                    end
                end
                MODE_REVERSE:
                begin
                    rev_next = !rev_reg;
                end
                MODE_READ:
                begin
                    if (CMP_W'(index) >= CMP_W'(count_reg))
                    begin
                        res_next.status = STATUS_EMPTY;
                    end
                    else
                    begin
                        req.rd_en      = 1'b1;
                        res_next.rd_ok = 1'b1;
                        // count from the far end while reversed
                        off = rev_reg ? AW'(count_reg - CW'(1) - CW'(index))
                                      : AW'(index);
                        req.addr = wrap_pos((AW+1)'(head_reg) + (AW+1)'(off));
                    end
                end
                default:
                begin
                    res_next.status = STATUS_OK;
                end
            endcase
        end

        res_next.count = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            rev_reg   <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            rev_reg   <= rev_next;
        end
    end

endmodule

### sv/reversible_char_deque.sv
// The result of an operation is registered and appears on the result ports in the cycle after it is taken.
// Throughput: one operation per cycle; busy is never raised.
// Every operation makes at most one access to the single-port byte store.
// done strobes for exactly one cycle; the receiver cannot stall it.
// Reset clears head pointer, count and orientation; the byte store is not cleared.
module reversible_char_deque
    import rcd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [MODE_W-1:0] mode,
    input  logic [VAL_W-1:0]  value,
    input  logic [IDX_W-1:0]  index,
    output logic              done,
    output logic [VAL_W-1:0]  data,
    output logic [STAT_W-1:0] status,
    output logic [OCC_W-1:0]  occupancy
);

    logic             accept;
    mem_req_t         req;
    op_result_t       res_next;
    op_result_t       res_reg;
    logic             done_reg;
    logic [VAL_W-1:0] rdata;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    rcd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .mode     (mode),
        .value    (value),
        .index    (index),
        .req      (req),
        .res_next (res_next)
    );

    rcd_mem u_mem
    (
        .clk   (clk),
        .req   (req),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            res_reg  <= '0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                res_reg <= res_next;
            end
        end
    end

    // drop the stale read data unless this beat popped or read a byte
    assign done      = done_reg;
    assign data      = res_reg.rd_ok ? rdata : '0;
    assign status    = res_reg.status;
    assign occupancy = OCC_W'(res_reg.count);

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("no result one cycle after an accepted operation");

    a_full_only_at_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STATUS_FULL) |-> (occupancy == OCC_W'(DEPTH)))
        else $error("push reported full below capacity");

    a_fail_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != STATUS_OK) |-> (data == '0))
        else $error("failed operation returned a byte");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (occupancy <= OCC_W'(DEPTH)))
        else $error("occupancy above capacity");

endmodule
